// ----- rtl/cps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the plate decode and color softmax unit.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int SCORE_BITS = 16;
  localparam int LABEL_BITS = 7;
  localparam int CONF_BITS = 16;
  localparam int EXP_BITS = 12;
  localparam int Q32_ONE_BITS = 33;
  localparam logic [31:0] EXP_NEG_STEP = 32'd4278222805;
  localparam logic [Q32_ONE_BITS-1:0] EXP_ONE = {1'b1, 32'd0};

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_COLOR = 1'b1;
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  localparam logic REG_CHAR_CLASSES = 1'b0;
  localparam logic REG_COLOR_CLASSES = 1'b1;

  typedef struct packed {
    logic cmd;
    logic signed [SCORE_BITS-1:0] score;
  } in_t;

  typedef struct packed {
    logic kind;
    logic [LABEL_BITS-1:0] label;
    logic [CONF_BITS-1:0] confidence;
    logic last;
  } out_t;

  typedef struct packed {
    logic start;
    logic ack;
  } sm_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic [CONF_BITS-1:0] conf;
  } sm_stat_t;

endpackage
`default_nettype wire

// ----- rtl/ctc_plate_decode_and_color_softmax_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_plate_decode_and_color_softmax_unit
// CTC greedy character decode with color argmax and softmax confidence.
// ----------------------------------------------------------------------------
// Character and non-final color scores: one beat per cycle while the softmax
// engine is idle and the output is free; a character result is registered
// in the cycle after the row's last score. Final color score: the engine walks
// the color memory, sums exp of each logit, divides, then loads the output.
// Reset: synchronous; clears counters and control state, not the output data.
// ----------------------------------------------------------------------------
module ctc_plate_decode_and_color_softmax_unit #(
  parameter int MAX_CHAR_CLASSES = 128,
  parameter int MAX_COLOR_CLASSES = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire cps_pkg::in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output cps_pkg::out_t    out_data,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [2:0]        paddr,
  input  wire [31:0]       pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PW = (MAX_CHAR_CLASSES > 1) ? $clog2(MAX_CHAR_CLASSES) : 1;
  localparam int QW = (MAX_COLOR_CLASSES > 1) ? $clog2(MAX_COLOR_CLASSES) : 1;

  logic [7:0] char_classes;
  logic [4:0] color_classes;
  logic [7:0] char_cnt;
  logic [4:0] color_cnt;

  logic signed [cps_pkg::SCORE_BITS-1:0] row_best_score;
  logic [PW-1:0] row_best_index;
  logic [PW-1:0] row_position;
  logic [cps_pkg::LABEL_BITS-1:0] previous_label;
  logic signed [cps_pkg::SCORE_BITS-1:0] color_best_score;
  logic [QW-1:0] color_best_index;
  logic [QW-1:0] color_position;

  logic accept;
  logic is_char;
  logic is_color;
  logic row_upd;
  logic [PW-1:0] row_best_index_next;
  logic row_end;
  logic [cps_pkg::LABEL_BITS-1:0] row_label;
  logic char_emit;
  logic col_upd;
  logic signed [cps_pkg::SCORE_BITS-1:0] color_best_score_next;
  logic [QW-1:0] color_best_index_next;
  logic col_end;

  cps_pkg::sm_ctrl_t sm_ctrl;
  cps_pkg::sm_stat_t sm_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cps_pkg::REG_COLOR_CLASSES) ? {27'd0, color_classes}
                                                          : {24'd0, char_classes};

  always_ff @(posedge clk) begin
    if (rst) begin
      char_classes <= 8'd64;
      color_classes <= 5'd5;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == cps_pkg::REG_CHAR_CLASSES) begin
        char_classes <= pwdata[7:0];
      end else begin
        color_classes <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    if (char_classes < 8'd2) begin
      char_cnt = 8'd2;
    end else if (char_classes > 8'(MAX_CHAR_CLASSES)) begin
      char_cnt = 8'(MAX_CHAR_CLASSES);
    end else begin
      char_cnt = char_classes;
    end
    if (color_classes < 5'd1) begin
      color_cnt = 5'd1;
    end else if (color_classes > 5'(MAX_COLOR_CLASSES)) begin
      color_cnt = 5'(MAX_COLOR_CLASSES);
    end else begin
      color_cnt = color_classes;
    end
  end

  assign in_ready = sm_stat.idle && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;
  assign is_char = accept && (in_data.cmd == cps_pkg::CMD_CHAR);
  assign is_color = accept && (in_data.cmd == cps_pkg::CMD_COLOR);

  assign row_upd = (row_position == '0) || (in_data.score > row_best_score);
  assign row_best_index_next = row_upd ? row_position : row_best_index;
  assign row_end = (8'(row_position) + 8'd1) >= char_cnt;
  assign row_label = cps_pkg::LABEL_BITS'(row_best_index_next);
  assign char_emit = row_end && (row_label != '0) && (row_label != previous_label);

  assign col_upd = (color_position == '0) || (in_data.score > color_best_score);
  assign color_best_score_next = col_upd ? in_data.score : color_best_score;
  assign color_best_index_next = col_upd ? color_position : color_best_index;
  assign col_end = (5'(color_position) + 5'd1) >= color_cnt;

  assign sm_ctrl.start = is_color && col_end;
  assign sm_ctrl.ack = sm_stat.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_best_score <= '0;
      row_best_index <= '0;
      row_position <= '0;
      previous_label <= '0;
      color_best_score <= '0;
      color_best_index <= '0;
      color_position <= '0;
    end else begin
      if (is_char) begin
        if (row_upd) begin
          row_best_score <= in_data.score;
        end
        row_best_index <= row_best_index_next;
        if (row_end) begin
          row_position <= '0;
          previous_label <= row_label;
        end else begin
          row_position <= row_position + PW'(1);
        end
      end
      if (is_color) begin
        color_best_score <= color_best_score_next;
        color_best_index <= color_best_index_next;
        if (col_end) begin
          color_position <= '0;
          previous_label <= '0;
        end else begin
          color_position <= color_position + QW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_char && char_emit) begin
      out_valid <= 1'b1;
    end else if (sm_ctrl.ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_char && char_emit) begin
      out_data.kind <= cps_pkg::KIND_CHAR;
      out_data.label <= row_label;
      out_data.confidence <= '0;
      out_data.last <= 1'b0;
    end else if (sm_ctrl.ack) begin
      out_data.kind <= cps_pkg::KIND_COLOR;
      out_data.label <= cps_pkg::LABEL_BITS'(color_best_index);
      out_data.confidence <= sm_stat.conf;
      out_data.last <= 1'b1;
    end
  end

  cps_softmax #(
    .DEPTH (MAX_COLOR_CLASSES),
    .AW    (QW)
  ) u_softmax (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (is_color),
    .wr_addr  (color_position),
    .wr_data  (in_data.score),
    .last_idx (color_position),
    .best     (color_best_score_next),
    .ctrl     (sm_ctrl),
    .stat     (sm_stat)
  );

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == out_data.kind))
    else $error("last flag disagrees with result kind");
  a_char_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == cps_pkg::KIND_CHAR) |->
      (out_data.confidence == '0 && out_data.label != '0))
    else $error("bad character result");
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    sm_ctrl.start |=> !in_ready)
    else $error("input taken while softmax runs");

endmodule
`default_nettype wire

// ----- rtl/cps_softmax.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cps_softmax
// Color logit memory and iterative softmax confidence engine: reads each
// stored logit, forms exp(-d) by 12 multiply steps, sums, then divides.
// ----------------------------------------------------------------------------
module cps_softmax #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  wr_en,
  input  wire [AW-1:0]                         wr_addr,
  input  wire signed [cps_pkg::SCORE_BITS-1:0] wr_data,
  input  wire [AW-1:0]                         last_idx,
  input  wire signed [cps_pkg::SCORE_BITS-1:0] best,
  input  wire cps_pkg::sm_ctrl_t               ctrl,
  output cps_pkg::sm_stat_t                    stat
);

  localparam int SUM_W = 33 + $clog2(DEPTH + 1);
  localparam int QB = 17;
  localparam int NUM_W = 49;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_LOAD = 7'b0000100,
    S_EXP  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  logic signed [cps_pkg::SCORE_BITS-1:0] mem [DEPTH];
  logic signed [cps_pkg::SCORE_BITS-1:0] rd_data;

  state_t state;
  logic [AW-1:0] idx;
  logic [AW-1:0] last_r;
  logic signed [cps_pkg::SCORE_BITS-1:0] best_r;
  logic [cps_pkg::SCORE_BITS-1:0] dreg;
  logic dzero;
  logic [3:0] step;
  logic [cps_pkg::Q32_ONE_BITS-1:0] r;
  logic [31:0] c;
  logic [SUM_W-1:0] sum;
  logic [SUM_W:0] rem;
  logic [NUM_W-1:0] num;
  logic [QB-1:0] quo;
  logic [4:0] qcnt;

  logic signed [cps_pkg::SCORE_BITS:0] diff;
  logic [cps_pkg::Q32_ONE_BITS+31:0] rc_prod;
  logic [63:0] cc_prod;
  logic [SUM_W:0] rem_sh;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx];
  end

  assign diff = {best_r[cps_pkg::SCORE_BITS-1], best_r} - {rd_data[cps_pkg::SCORE_BITS-1], rd_data};
  assign rc_prod = r * {{(cps_pkg::Q32_ONE_BITS){1'b0}}, c};
  assign cc_prod = {32'd0, c} * {32'd0, c};
  assign rem_sh = {rem[SUM_W-1:0], num[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: state <= S_EXP;
        S_EXP: begin
          if (step == 4'(cps_pkg::EXP_BITS - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (idx == last_r) begin
            state <= S_DIV;
          end else begin
            state <= S_RD;
          end
        end
        S_DIV: begin
          if (qcnt == 5'(QB - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctrl.ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx <= '0;
        sum <= '0;
        last_r <= last_idx;
        best_r <= best;
      end
      S_LOAD: begin
        dreg <= diff[cps_pkg::SCORE_BITS-1:0];
        dzero <= (diff[cps_pkg::SCORE_BITS-1:cps_pkg::EXP_BITS] != '0);
        r <= cps_pkg::EXP_ONE;
        c <= cps_pkg::EXP_NEG_STEP;
        step <= '0;
      end
      S_EXP: begin
        if (dreg[step]) begin
          r <= rc_prod[cps_pkg::Q32_ONE_BITS+31:32];
        end
        c <= cc_prod[63:32];
        step <= step + 4'd1;
      end
      S_ACC: begin
        sum <= sum + (dzero ? '0 : SUM_W'(r));
        idx <= idx + AW'(1);
        num <= {1'b1, 48'd0} + NUM_W'((sum + (dzero ? '0 : SUM_W'(r))) >> 1);
        rem <= '0;
        qcnt <= '0;
        quo <= '0;
      end
      S_DIV: begin
        if (qcnt == 5'd0 && quo == '0 && rem == '0) begin
          rem <= (SUM_W+1)'(num[NUM_W-1:QB]);
          num <= num << (NUM_W - QB);
          qcnt <= 5'd0;
          quo <= {1'b1, {(QB-1){1'b0}}};
        end else begin
          if (rem_sh >= {1'b0, sum}) begin
            rem <= rem_sh - {1'b0, sum};
            quo <= {quo[QB-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[QB-2:0], 1'b0};
          end
          num <= num << 1;
          qcnt <= qcnt + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);
  assign stat.conf = quo[QB-1] ? '1 : quo[cps_pkg::CONF_BITS-1:0];

  a_sum_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (sum[SUM_W-1:32] != '0))
    else $error("softmax sum below the maximum term");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (rem < {1'b0, sum}))
    else $error("division remainder out of range");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !ctrl.start)
    else $error("softmax started while busy");

endmodule
`default_nettype wire

// ----- test/tb_ctc_plate_decode_and_color_softmax_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ctc_plate_decode_and_color_softmax_unit
// Streams character rows and color records through the unit with random
// gaps and output stalls, and reprograms both class counts between phases.
// A local model of the greedy collapse and the fixed-point softmax predicts
// every result beat, and each beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_ctc_plate_decode_and_color_softmax_unit;

  localparam logic [1:0] OP_BEAT = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;
  localparam logic [2:0] ADDR_CHAR = 3'd0;
  localparam logic [2:0] ADDR_COLOR = 3'd4;
  localparam int SETTLE_CYCLES = 400;
  localparam int ITEM_TARGET = 1700;

  typedef struct packed {
    logic [1:0] op;
    cps_pkg::in_t beat;
    logic [2:0] addr;
    logic [31:0] wdata;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cps_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cps_pkg::out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ctc_plate_decode_and_color_softmax_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stim_t stim_q[$];
  cps_pkg::out_t result_q[$];
  int mismatches = 0;
  int item_count = 0;

  // local copy of the decoder state
  logic [7:0] char_reg;
  logic [4:0] color_reg;
  int row_best;
  int row_idx;
  int row_pos;
  int prev_label;
  int color_logit[16];
  int color_best;
  int color_idx;
  int color_pos;

  function automatic logic [63:0] exp_neg(logic [63:0] d);
    logic [63:0] r;
    logic [63:0] c;
    r = 64'h1_0000_0000;
    c = {32'd0, cps_pkg::EXP_NEG_STEP};
    if (d >= 64'd4096) return 64'd0;
    for (int j = 0; j < 12; j++) begin
      if (d[j]) r = (r * c) >> 32;
      c = (c * c) >> 32;
    end
    return r;
  endfunction

  function automatic void predict_decode(cps_pkg::in_t b);
    int s;
    int n;
    int pos;
    logic [63:0] sum;
    logic [63:0] conf;
    cps_pkg::out_t r;
    s = int'(b.score);
    r = '0;
    if (b.cmd == cps_pkg::CMD_CHAR) begin
      n = (char_reg < 2) ? 2 : ((char_reg > 128) ? 128 : int'(char_reg));
      if (row_pos == 0 || s > row_best) begin
        row_best = s;
        row_idx = row_pos & 127;
      end
      if (row_pos + 1 < n) begin
        row_pos++;
      end else begin
        row_pos = 0;
        if (row_idx != 0 && row_idx != prev_label) begin
          r.kind = cps_pkg::KIND_CHAR;
          r.label = row_idx[6:0];
          result_q = {result_q, r};
        end
        prev_label = row_idx;
      end
    end else begin
      n = (color_reg < 1) ? 1 : ((color_reg > 16) ? 16 : int'(color_reg));
      pos = (color_pos > 15) ? 15 : color_pos;
      color_logit[pos] = s;
      if (pos == 0 || s > color_best) begin
        color_best = s;
        color_idx = pos & 15;
      end
      if (pos + 1 < n) begin
        color_pos = pos + 1;
      end else begin
        sum = 64'd0;
        for (int i = 0; i <= pos; i++)
          sum += exp_neg(64'(color_best - color_logit[i]));
        conf = ((64'd1 << 48) + (sum >> 1)) / sum;
        if (conf > 64'd65535) conf = 64'd65535;
        r.kind = cps_pkg::KIND_COLOR;
        r.label = color_idx[6:0];
        r.confidence = conf[15:0];
        r.last = 1'b1;
        result_q = {result_q, r};
        color_pos = 0;
        prev_label = 0;
      end
    end
  endfunction

  // driver
  int gap = 0;
  int settle = 0;
  bit burst = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else if (psel && !penable) begin
      penable <= 1'b1;
    end else if (psel && penable) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (stim_q[0].addr == ADDR_CHAR) char_reg = stim_q[0].wdata[7:0];
      else color_reg = stim_q[0].wdata[4:0];
      void'(stim_q.pop_front());
    end else begin
      if (in_valid && in_ready) begin
        predict_decode(in_data);
        void'(stim_q.pop_front());
        if ($urandom_range(0, 40) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 12);
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (stim_q[0].op == OP_BEAT) begin
          in_valid <= 1'b1;
          in_data <= stim_q[0].beat;
        end else begin
          in_valid <= 1'b0;
          if (!in_valid && result_q.size() == 0) begin
            if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              settle = 0;
              if (stim_q[0].op == OP_WRITE) begin
                psel <= 1'b1;
                pwrite <= 1'b1;
                paddr <= stim_q[0].addr;
                pwdata <= stim_q[0].wdata;
              end else begin
                void'(stim_q.pop_front());
              end
            end
          end
        end
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", out_data);
        end else begin
          if (out_data.kind !== result_q[0].kind || out_data.label !== result_q[0].label ||
              out_data.confidence !== result_q[0].confidence ||
              out_data.last !== result_q[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", result_q[0], out_data);
          end
          void'(result_q.pop_front());
        end
        stall = burst ? 0 : $urandom_range(0, 12);
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  task automatic add_beat(logic cmd, int score);
    stim_t e;
    e = '0;
    e.op = OP_BEAT;
    e.beat.cmd = cmd;
    e.beat.score = score[15:0];
    stim_q = {stim_q, e};
    item_count++;
  endtask

  task automatic add_write(logic [2:0] addr, logic [31:0] val);
    stim_t e;
    e = '0;
    e.op = OP_DRAIN;
    stim_q = {stim_q, e};
    e.op = OP_WRITE;
    e.addr = addr;
    e.wdata = val;
    stim_q = {stim_q, e};
  endtask

  task automatic add_row(int n, int peak);
    int base;
    base = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 65535)) - 32768
                                     : int'($urandom_range(0, 40)) - 20;
    for (int i = 0; i < n; i++) begin
      if (i == peak) add_beat(cps_pkg::CMD_CHAR, 32767);
      else if ($urandom_range(0, 7) == 0)
        add_beat(cps_pkg::CMD_CHAR, int'($urandom_range(0, 65535)));
      else add_beat(cps_pkg::CMD_CHAR, base + int'($urandom_range(0, 6)) - 3);
    end
  endtask

  task automatic add_record(int n);
    int spread;
    spread = 1 << $urandom_range(0, 15);
    for (int i = 0; i < n; i++)
      add_beat(cps_pkg::CMD_COLOR, int'($urandom_range(0, spread)) - spread / 2);
  endtask

  // repeat a small label often so the collapse of equal neighbors is hit
  function automatic int prev_pick(int n);
    return (n > 1) ? 1 : 0;
  endfunction

  initial begin
    int nc;
    int nk;
    char_reg = 8'd64;
    color_reg = 5'd5;
    row_best = 0; row_idx = 0; row_pos = 0; prev_label = 0;
    color_best = 0; color_idx = 0; color_pos = 0;
    foreach (color_logit[i]) color_logit[i] = 0;

    // directed part
    add_write(ADDR_CHAR, 32'd3);
    add_write(ADDR_COLOR, 32'd2);
    add_beat(cps_pkg::CMD_CHAR, 32767); add_beat(cps_pkg::CMD_CHAR, 0);
    add_beat(cps_pkg::CMD_CHAR, 0);
    add_beat(cps_pkg::CMD_CHAR, -32768); add_beat(cps_pkg::CMD_CHAR, 32767);
    add_beat(cps_pkg::CMD_CHAR, 32767);
    add_beat(cps_pkg::CMD_CHAR, 5); add_beat(cps_pkg::CMD_CHAR, 9);
    add_beat(cps_pkg::CMD_COLOR, 100);
    add_beat(cps_pkg::CMD_CHAR, 9);
    add_beat(cps_pkg::CMD_CHAR, -32768); add_beat(cps_pkg::CMD_CHAR, 0);
    add_beat(cps_pkg::CMD_CHAR, -1);
    add_beat(cps_pkg::CMD_COLOR, 32767);
    add_beat(cps_pkg::CMD_COLOR, -32768); add_beat(cps_pkg::CMD_COLOR, 7);
    add_write(ADDR_COLOR, 32'd1);
    add_beat(cps_pkg::CMD_COLOR, -32768);
    add_write(ADDR_CHAR, 32'd8);
    for (int i = 0; i < 5; i++) add_beat(cps_pkg::CMD_CHAR, i);
    add_write(ADDR_CHAR, 32'd4);
    add_beat(cps_pkg::CMD_CHAR, 1);
    add_write(ADDR_CHAR, 32'd0);
    add_write(ADDR_COLOR, 32'd16);
    add_beat(cps_pkg::CMD_CHAR, 3); add_beat(cps_pkg::CMD_CHAR, 4);
    add_record(16);

    // random phases
    while (item_count < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: nk = 128;
        1: nk = $urandom_range(0, 255);
        default: nk = $urandom_range(2, 10);
      endcase
      nc = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
      add_write(ADDR_CHAR, $urandom() & 32'hffff_ff00 | nk);
      add_write(ADDR_COLOR, $urandom() & 32'hffff_ffe0 | nc);
      if (nk < 2) nk = 2;
      if (nk > 128) nk = 128;
      if (nc < 1) nc = 1;
      if (nc > 16) nc = 16;
      for (int p = 0; p < ((nk > 16) ? 4 : 30); p++) begin
        case ($urandom_range(0, 9))
          0: add_beat(1'($urandom_range(0, 1)), int'($urandom_range(0, 65535)));
          1, 2: add_record(nc);
          3: add_row(nk, 0);
          default: add_row(nk, $urandom_range(0, 3) == 0 ? prev_pick(nk) : $urandom_range(0, nk - 1));
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        stim_t e;
        e = '0;
        e.op = OP_DRAIN;
        stim_q = {stim_q, e};
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (stim_q.size() == 0 && !in_valid && result_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(8 * 4000000);
    $display("Some tests failed");
    $finish;
  end

endmodule
